// File: hw/rtl/staging_ring_reserve_commit_core_macros.svh
// Assertion shorthands for the staging ring core and its checker.
// The including scope provides i_clk and i_rst_n.
`ifndef STAGING_RING_RESERVE_COMMIT_CORE_MACROS_SVH
`define STAGING_RING_RESERVE_COMMIT_CORE_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define SRRC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("srrc assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define SRRC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("srrc assertion failed");

// Next-cycle implication that is checked through reset as well.
`define SRRC_ASSERT_ALWAYS_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("srrc assertion failed");

`endif

// File: hw/rtl/srrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srrc_pkg;

    localparam int unsigned RING_BYTES_DEF = 65536;
    localparam int unsigned CNT_W          = 17;
    localparam int unsigned OFF_W          = 17;
    localparam int unsigned STAT_W         = 2;
    localparam int unsigned REQ_W          = 2;
    localparam int unsigned IN_DATA_W      = 24;
    localparam int unsigned OUT_DATA_W     = 40;

    typedef enum logic [REQ_W-1:0] {
        REQ_RESERVE = 2'd0,
        REQ_FINISH  = 2'd1,
        REQ_PEEK    = 2'd2,
        REQ_CONSUME = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_RETRY  = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [OFF_W-1:0]   avail;
        logic [OFF_W-1:0]   offset;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/srrc_calc.sv
`timescale 1ns / 1ps
`default_nettype none

// Next pointer state and result for one request.
module srrc_calc #(
    parameter int unsigned RING_BYTES = srrc_pkg::RING_BYTES_DEF
) (
    input  srrc_pkg::t_req                  i_req,
    input  wire  [srrc_pkg::CNT_W-1:0]      i_count,
    input  wire  [$clog2(RING_BYTES+1)-1:0] i_prod,
    input  wire  [$clog2(RING_BYTES+1)-1:0] i_cons,
    input  wire  [$clog2(RING_BYTES+1)-1:0] i_rend,
    input  wire  [$clog2(RING_BYTES+1)-1:0] i_hint,
    output logic [$clog2(RING_BYTES+1)-1:0] o_prod,
    output logic [$clog2(RING_BYTES+1)-1:0] o_cons,
    output logic [$clog2(RING_BYTES+1)-1:0] o_rend,
    output logic [$clog2(RING_BYTES+1)-1:0] o_hint,
    output srrc_pkg::t_result               o_res
);

    localparam int unsigned PW = $clog2(RING_BYTES + 1);
    localparam int unsigned CW = ((PW > srrc_pkg::CNT_W) ? PW : srrc_pkg::CNT_W) + 1;
    localparam logic [CW-1:0] RING = CW'(RING_BYTES);

    logic [CW-1:0] n, p, c, e, h;
    logic [CW-1:0] tail, gap, p_adv, c_adv, limit;
    logic [CW-1:0] span_top, span_low;

    assign n        = CW'(i_count);
    assign p        = CW'(i_prod);
    assign c        = CW'(i_cons);
    assign e        = CW'(i_rend);
    assign h        = CW'(i_hint);
    assign tail     = RING - p;
    assign gap      = c - p;
    assign p_adv    = p + n;
    assign c_adv    = c + n;
    assign limit    = (p >= c) ? p : e;
    assign span_top = e - c;
    assign span_low = p - c;

    always_comb begin
        o_prod        = i_prod;
        o_cons        = i_cons;
        o_rend        = i_rend;
        o_hint        = i_hint;
        o_res.status  = srrc_pkg::ST_OK;
        o_res.avail   = '0;
        o_res.offset  = p[srrc_pkg::OFF_W-1:0];
        case (i_req)
            srrc_pkg::REQ_RESERVE: begin
                if (n < h) begin
                    o_res.status = srrc_pkg::ST_OK;
                end else if (c <= p) begin
                    if (tail > n) begin
                        o_hint = tail[PW-1:0];
                    end else begin
                        // Tail too short: mark end of data, wrap unless reader is at zero
                        o_rend = i_prod;
                        if (c != '0) begin
                            o_prod       = '0;
                            o_hint       = i_cons;
                            o_res.offset = '0;
                            o_res.status = (c <= n) ? srrc_pkg::ST_RETRY : srrc_pkg::ST_OK;
                        end else begin
                            o_hint       = tail[PW-1:0];
                            o_res.status = srrc_pkg::ST_RETRY;
                        end
                    end
                end else begin
                    o_hint       = gap[PW-1:0];
                    o_res.status = (gap <= n) ? srrc_pkg::ST_RETRY : srrc_pkg::ST_OK;
                end
            end
            srrc_pkg::REQ_FINISH: begin
                if ((n < h) && (p_adv < RING)) begin
                    o_prod       = p_adv[PW-1:0];
                    o_hint       = PW'(h - n);
                    o_res.offset = p_adv[srrc_pkg::OFF_W-1:0];
                end else begin
                    o_res.status = srrc_pkg::ST_REJECT;
                end
            end
            srrc_pkg::REQ_PEEK: begin
                if ((p < c) && (e > c)) begin
                    o_res.offset = c[srrc_pkg::OFF_W-1:0];
                    o_res.avail  = span_top[srrc_pkg::OFF_W-1:0];
                end else if (p < c) begin
                    // Upper span used up: roll the reader over
                    o_cons       = '0;
                    o_res.offset = '0;
                    o_res.avail  = p[srrc_pkg::OFF_W-1:0];
                end else begin
                    o_res.offset = c[srrc_pkg::OFF_W-1:0];
                    o_res.avail  = span_low[srrc_pkg::OFF_W-1:0];
                end
            end
            srrc_pkg::REQ_CONSUME: begin
                o_res.offset = c[srrc_pkg::OFF_W-1:0];
                if ((limit >= c) && (c_adv <= limit)) begin
                    o_cons       = c_adv[PW-1:0];
                    o_res.offset = c_adv[srrc_pkg::OFF_W-1:0];
                end else begin
                    o_res.status = srrc_pkg::ST_REJECT;
                end
            end
            default: begin
                o_res.status = srrc_pkg::ST_REJECT;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/staging_ring_reserve_commit_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Pointer manager for a byte ring that hands out contiguous regions (a
// bipartite circular buffer). Each request on the slave stream (tuser selects
// reserve, finish, peek or consume; tdata carries the byte count) gives exactly
// one result on the master stream: an offset, the contiguous readable span for
// a peek, and a status of ok, retry (no space yet) or reject. One request is
// taken every clock cycle unless the master side stalls; it goes from the input
// register through one pass of the pointer logic to the result register. A
// request updates the producer, consumer, recorded-end and free-hint registers
// in the cycle it moves into the result register, so the next request always
// sees the fully updated pointers. A stalled master side holds the result and,
// once the input register is full too, drops s_axis_tready.
module staging_ring_reserve_commit_core #(
    parameter int unsigned RING_BYTES = srrc_pkg::RING_BYTES_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [16:0] byte_count, rest zero
    input  wire  [srrc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] req_type
    input  wire  [srrc_pkg::REQ_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [16:0] offset, [33:17] bytes_available, [35:34] status, rest zero
    output logic [srrc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int unsigned PW = $clog2(RING_BYTES + 1);
    localparam int unsigned PAD_W = srrc_pkg::OUT_DATA_W - $bits(srrc_pkg::t_result);

    // Input register
    logic                          r_in_valid;
    srrc_pkg::t_req                r_in_req;
    logic [srrc_pkg::CNT_W-1:0]    r_in_cnt;

    // Ring pointers
    logic [PW-1:0]                 r_prod, r_cons, r_rend, r_hint;
    logic [PW-1:0]                 n_prod, n_cons, n_rend, n_hint;

    // Result register
    logic                          r_out_valid;
    srrc_pkg::t_result             r_out_res;
    srrc_pkg::t_result             n_res;

    logic                          s_take;
    logic                          advance;

    // Move the held request on whenever the result slot is free or being drained
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    srrc_calc #(
        .RING_BYTES (RING_BYTES)
    ) u_calc (
        .i_req   (r_in_req),
        .i_count (r_in_cnt),
        .i_prod  (r_prod),
        .i_cons  (r_cons),
        .i_rend  (r_rend),
        .i_hint  (r_hint),
        .o_prod  (n_prod),
        .o_cons  (n_cons),
        .o_rend  (n_rend),
        .o_hint  (n_hint),
        .o_res   (n_res)
    );

    // Capture a transaction from the slave side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_req <= srrc_pkg::t_req'(s_axis_tuser);
            r_in_cnt <= s_axis_tdata[srrc_pkg::CNT_W-1:0];
        end
    end

    // Commit pointer updates together with the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod <= '0;
            r_cons <= '0;
            r_rend <= PW'(RING_BYTES);
            r_hint <= '0;
        end else if (advance) begin
            r_prod <= n_prod;
            r_cons <= n_cons;
            r_rend <= n_rend;
            r_hint <= n_hint;
        end
    end

    // Hold the result until the master side takes the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_res};

endmodule

`default_nettype wire

// File: hw/rtl/srrc_chk.sv
`timescale 1ns / 1ps
`default_nettype none

`include "staging_ring_reserve_commit_core_macros.svh"

module srrc_chk (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             s_axis_tvalid,
    input wire                             s_axis_tready,
    input wire                             m_axis_tvalid,
    input wire                             m_axis_tready,
    input wire [srrc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    logic [srrc_pkg::STAT_W-1:0] st;
    logic [srrc_pkg::OFF_W-1:0]  avail;
    logic                        st_known;
    logic                        out_stall;

    assign st        = m_axis_tdata[2*srrc_pkg::OFF_W +: srrc_pkg::STAT_W];
    assign avail     = m_axis_tdata[srrc_pkg::OFF_W +: srrc_pkg::OFF_W];
    assign st_known  = st inside {srrc_pkg::ST_OK, srrc_pkg::ST_RETRY, srrc_pkg::ST_REJECT};
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // A stalled result must hold
    `SRRC_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // Status is always a defined code
    `SRRC_ASSERT_IMP(a_status_code, m_axis_tvalid, st_known)

    // Only a successful peek reports readable bytes
    `SRRC_ASSERT_IMP(a_avail_ok, m_axis_tvalid && (avail != '0), st == srrc_pkg::ST_OK)

    // Reset empties the result slot
    `SRRC_ASSERT_ALWAYS_NXT(a_rst_empty, !i_rst_n, !m_axis_tvalid)

    // With the result slot free, the slave side is never stalled
    `SRRC_ASSERT_IMP(a_ready_free, !m_axis_tvalid && s_axis_tvalid, s_axis_tready)

endmodule

bind staging_ring_reserve_commit_core srrc_chk u_srrc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
